// ===== sv/wtt_pkg.sv =====
// ----------------------------------------------------------------------------
// Wedge splitter package
// Shared types, lookup tables and helpers for the wedge / quad-face splitter.
// ----------------------------------------------------------------------------
package wtt_pkg;

  // Port widths of one node id and one group id
  localparam int unsigned IdW  = 32;
  localparam int unsigned GrpW = 16;

  // Significant bits of a node id; higher bits are cleared on entry
  localparam int unsigned NODE_ID_BITS = 32;

  typedef logic [IdW-1:0]  id_t;
  typedef logic [GrpW-1:0] grp_t;
  typedef logic [2:0]      loc_t;   // local node index 0..5

  typedef enum logic {
    CMD_WEDGE = 1'b0,
    CMD_QUAD  = 1'b1
  } cmd_e;

  // Renumbering of the wedge so that local node r becomes node 0
  localparam loc_t RotTab [6][6] = '{
    '{3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5},
    '{3'd1, 3'd2, 3'd0, 3'd4, 3'd5, 3'd3},
    '{3'd2, 3'd0, 3'd1, 3'd5, 3'd3, 3'd4},
    '{3'd3, 3'd4, 3'd5, 3'd0, 3'd1, 3'd2},
    '{3'd4, 3'd5, 3'd3, 3'd1, 3'd2, 3'd0},
    '{3'd5, 3'd3, 3'd4, 3'd2, 3'd0, 3'd1}
  };

  // Corners of the quad face whose diagonal is still open, in face order
  localparam loc_t FreeFace [4] = '{3'd2, 3'd5, 3'd4, 3'd1};

  // Three tetrahedra for diagonal 2-4 (index 0) and diagonal 1-5 (index 1)
  localparam loc_t TetTab [2][3][4] = '{
    '{'{3'd0, 3'd3, 3'd4, 3'd5}, '{3'd0, 3'd1, 3'd2, 3'd4}, '{3'd0, 3'd4, 3'd2, 3'd5}},
    '{'{3'd0, 3'd3, 3'd4, 3'd5}, '{3'd0, 3'd5, 3'd4, 3'd1}, '{3'd0, 3'd1, 3'd2, 3'd5}}
  };

  // One element on its way through the ordering pipeline
  typedef struct packed {
    cmd_e                  cmd;
    logic [5:0][IdW-1:0]   n;     // node ids, renumbered from the rotate stage on
    grp_t                  grp;
    loc_t                  l;     // lowest local node
    logic                  sel;   // 1: split along diagonal 1-5
  } item_t;

  // One produced tetrahedron or triangle
  typedef struct packed {
    logic [3:0][IdW-1:0]   c;
    grp_t                  grp;
    logic                  last;
  } piece_t;

  // Clear node id bits above the significant width
  function automatic id_t mask_id(id_t v);
    id_t r;
    for (int b = 0; b < IdW; b++) begin
      r[b] = (b < NODE_ID_BITS) ? v[b] : 1'b0;
    end
    return r;
  endfunction

endpackage

// ===== sv/wtt_if.sv =====
// ----------------------------------------------------------------------------
// Wedge splitter channels
// Valid/ready channels for source elements and for produced pieces.
// ----------------------------------------------------------------------------
interface wtt_in_if import wtt_pkg::*; ();
  logic valid;
  logic ready;
  logic command;
  id_t  node0;
  id_t  node1;
  id_t  node2;
  id_t  node3;
  id_t  node4;
  id_t  node5;
  grp_t group_id;

  modport source (
    output valid, command, node0, node1, node2, node3, node4, node5, group_id,
    input  ready
  );
  modport sink (
    input  valid, command, node0, node1, node2, node3, node4, node5, group_id,
    output ready
  );
endinterface

interface wtt_out_if import wtt_pkg::*; ();
  logic valid;
  logic ready;
  id_t  corner0;
  id_t  corner1;
  id_t  corner2;
  id_t  corner3;
  grp_t piece_group;
  logic last;

  modport source (
    output valid, corner0, corner1, corner2, corner3, piece_group, last,
    input  ready
  );
  modport sink (
    input  valid, corner0, corner1, corner2, corner3, piece_group, last,
    output ready
  );
endinterface

// ===== sv/wtt_sort.sv =====
// ----------------------------------------------------------------------------
// Wedge splitter ordering pipeline
// Four stages: capture, lowest node search, renumbering, diagonal choice.
// ----------------------------------------------------------------------------
module wtt_sort import wtt_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  wtt_in_if.sink       in_i,
  output item_t        item_o,
  output logic         item_valid_o,
  input  logic         item_ready_i
);

  logic [3:0] v_q;
  item_t      s_q [4];
  item_t      s_d [4];
  logic [3:0] rdy;
  logic [3:0] up_v;

  // Stage handshake: a stage takes a word when empty or when it is moving on
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      up_v[k] = (k == 0) ? in_i.valid : v_q[(k == 0) ? 0 : k - 1];
    end
    rdy[3] = !v_q[3] || item_ready_i;
    for (int k = 2; k >= 0; k--) begin
      rdy[k] = !v_q[k] || rdy[k + 1];
    end
  end

  assign in_i.ready   = rdy[0];
  assign item_valid_o = v_q[3];
  assign item_o       = s_q[3];

  // Capture: mask node ids
  always_comb begin
    s_d[0].cmd  = cmd_e'(in_i.command);
    s_d[0].n[0] = mask_id(in_i.node0);
    s_d[0].n[1] = mask_id(in_i.node1);
    s_d[0].n[2] = mask_id(in_i.node2);
    s_d[0].n[3] = mask_id(in_i.node3);
    s_d[0].n[4] = mask_id(in_i.node4);
    s_d[0].n[5] = mask_id(in_i.node5);
    s_d[0].grp  = in_i.group_id;
    s_d[0].l    = '0;
    s_d[0].sel  = 1'b0;
  end

  // Lowest node: pairwise tree, the lower index wins a tie
  always_comb begin
    loc_t p01, p23, p45, q4, q6;
    p01 = (s_q[0].n[1] < s_q[0].n[0]) ? 3'd1 : 3'd0;
    p23 = (s_q[0].n[3] < s_q[0].n[2]) ? 3'd3 : 3'd2;
    p45 = (s_q[0].n[5] < s_q[0].n[4]) ? 3'd5 : 3'd4;
    q4  = (s_q[0].n[p23] < s_q[0].n[p01]) ? p23 : p01;
    q6  = (s_q[0].n[p45] < s_q[0].n[q4]) ? p45 : q4;
    s_d[1]   = s_q[0];
    s_d[1].l = (s_q[0].cmd == CMD_QUAD) ? q4 : q6;
  end

  // Renumber: rotate the wedge, or start the quad at its lowest corner
  always_comb begin
    loc_t src;
    s_d[2] = s_q[1];
    for (int k = 0; k < 6; k++) begin
      if (s_q[1].cmd == CMD_QUAD) begin
        if (k < 4) begin
          src = {1'b0, 2'(s_q[1].l[1:0] + 2'(k))};
        end else begin
          src = loc_t'(k);
        end
      end else begin
        src = RotTab[s_q[1].l][k];
      end
      s_d[2].n[k] = s_q[1].n[src];
    end
  end

  // Diagonal: lowest corner of the open face, an odd face position picks 1-5
  always_comb begin
    logic [1:0] a, b, m;
    a = (s_q[2].n[FreeFace[1]] < s_q[2].n[FreeFace[0]]) ? 2'd1 : 2'd0;
    b = (s_q[2].n[FreeFace[3]] < s_q[2].n[FreeFace[2]]) ? 2'd3 : 2'd2;
    m = (s_q[2].n[FreeFace[b]] < s_q[2].n[FreeFace[a]]) ? b : a;
    s_d[3]     = s_q[2];
    s_d[3].sel = m[0];
  end

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int k = 0; k < 4; k++) begin
        if (rdy[k]) begin
          v_q[k] <= up_v[k];
        end
      end
    end
  end

  // Advance payload
  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 4; k++) begin
      if (rdy[k] && up_v[k]) begin
        s_q[k] <= s_d[k];
      end
    end
  end

endmodule

// ===== sv/wtt_emit.sv =====
// ----------------------------------------------------------------------------
// Wedge splitter piece sequencer
// Holds one ordered element; issues its pieces one per cycle unless stalled.
// ----------------------------------------------------------------------------
module wtt_emit import wtt_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  item_t        item_i,
  input  logic         item_valid_i,
  output logic         item_ready_o,
  wtt_out_if.source    out_o
);

  logic       em_v_q, em_v_d;
  item_t      em_q;
  logic [1:0] cnt_q, cnt_d;
  logic       out_v_q, out_v_d;
  piece_t     pc_q, pc_d;
  logic       out_free;
  logic       fire;
  logic       last_pc;

  assign out_free     = !out_v_q || out_o.ready;
  assign fire         = em_v_q && out_free;
  assign last_pc      = (em_q.cmd == CMD_QUAD) ? (cnt_q == 2'd1) : (cnt_q == 2'd2);
  assign item_ready_o = !em_v_q || (fire && last_pc);

  // Build the current piece
  always_comb begin
    pc_d.grp  = em_q.grp;
    pc_d.last = last_pc;
    if (em_q.cmd == CMD_QUAD) begin
      pc_d.c[3] = '0;
      if (cnt_q == 2'd0) begin
        pc_d.c[0] = em_q.n[0];
        pc_d.c[1] = em_q.n[1];
        pc_d.c[2] = em_q.n[2];
      end else begin
        pc_d.c[0] = em_q.n[2];
        pc_d.c[1] = em_q.n[3];
        pc_d.c[2] = em_q.n[0];
      end
    end else begin
      for (int k = 0; k < 4; k++) begin
        pc_d.c[k] = em_q.n[TetTab[em_q.sel][cnt_q][k]];
      end
    end
  end

  // Load a new element, or step through the pieces of the held one
  always_comb begin
    em_v_d = em_v_q;
    cnt_d  = cnt_q;
    if (item_ready_o) begin
      em_v_d = item_valid_i;
      cnt_d  = '0;
    end else if (fire) begin
      cnt_d = cnt_q + 2'd1;
    end
    out_v_d = out_v_q;
    if (fire) begin
      out_v_d = 1'b1;
    end else if (out_o.ready) begin
      out_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      em_v_q  <= 1'b0;
      cnt_q   <= '0;
      out_v_q <= 1'b0;
    end else begin
      em_v_q  <= em_v_d;
      cnt_q   <= cnt_d;
      out_v_q <= out_v_d;
    end
  end

  // Hold element and output payload
  always_ff @(posedge clk_i) begin
    if (item_ready_o && item_valid_i) begin
      em_q <= item_i;
    end
    if (fire) begin
      pc_q <= pc_d;
    end
  end

  assign out_o.valid       = out_v_q;
  assign out_o.corner0     = pc_q.c[0];
  assign out_o.corner1     = pc_q.c[1];
  assign out_o.corner2     = pc_q.c[2];
  assign out_o.corner3     = pc_q.c[3];
  assign out_o.piece_group = pc_q.grp;
  assign out_o.last        = pc_q.last;

endmodule

// ===== sv/wedge_to_tetrahedra_split.sv =====
// Data passes the four ordering stages, the held element and the output register.
// The single piece sequencer issues one piece per cycle unless the output stalls;
// a wedge yields three tetrahedra, a quad face two triangles. The ordering stages
// accept an element every cycle unless backed up and fill while pieces go out.
// Reset (rst_ni low, asynchronous) empties every stage; no clearing pass follows.
// ----------------------------------------------------------------------------
// Wedge / quad-face splitter
// Splits a wedge into three tetrahedra or a quad face into two triangles
// along the diagonal through the lowest node id.
// ----------------------------------------------------------------------------
module wedge_to_tetrahedra_split import wtt_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  wtt_in_if.sink       in_i,
  wtt_out_if.source    out_o
);

  item_t item;
  logic  item_valid;
  logic  item_ready;

  // Order the nodes and choose the split
  wtt_sort u_sort (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .item_o       (item),
    .item_valid_o (item_valid),
    .item_ready_i (item_ready)
  );

  // Issue the pieces
  wtt_emit u_emit (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_i       (item),
    .item_valid_i (item_valid),
    .item_ready_o (item_ready),
    .out_o        (out_o)
  );

endmodule

// ===== sv/wtt_check.sv =====
// ----------------------------------------------------------------------------
// Wedge splitter port checker
// Watches the ports and checks piece grouping and counts over time.
// ----------------------------------------------------------------------------
module wtt_check import wtt_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic in_ready_i,
  input  logic out_valid_i,
  input  logic out_ready_i,
  input  id_t  corner0_i,
  input  id_t  corner1_i,
  input  id_t  corner2_i,
  input  id_t  corner3_i,
  input  grp_t piece_group_i,
  input  logic last_i
);

  logic       in_hs, out_hs;
  logic [3:0] pend_q, pend_d;
  logic [1:0] idx_q;
  grp_t       grp_q;

  assign in_hs  = in_valid_i && in_ready_i;
  assign out_hs = out_valid_i && out_ready_i;

  // Track elements in flight and the position within the current element
  always_comb begin
    pend_d = pend_q;
    if (in_hs) begin
      pend_d = pend_d + 4'd1;
    end
    if (out_hs && last_i) begin
      pend_d = pend_d - 4'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
      idx_q  <= '0;
      grp_q  <= '0;
    end else begin
      pend_q <= pend_d;
      if (out_hs) begin
        idx_q <= last_i ? 2'd0 : idx_q + 2'd1;
        grp_q <= piece_group_i;
      end
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(corner0_i) &&
    $stable(corner1_i) && $stable(corner2_i) && $stable(corner3_i) &&
    $stable(piece_group_i) && $stable(last_i))
    else $error("piece word changed while stalled");

  a_no_extra: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_hs && last_i |-> pend_q != 4'd0)
    else $error("final piece without an accepted element");

  a_same_grp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_hs && idx_q != 2'd0 |-> piece_group_i == grp_q)
    else $error("group changed inside one element");

  a_max_three: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_hs && idx_q == 2'd2 |-> last_i)
    else $error("more than three pieces for one element");

  a_min_two: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_hs && last_i |-> idx_q != 2'd0)
    else $error("element closed after a single piece");

endmodule

bind wedge_to_tetrahedra_split wtt_check u_wtt_check (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .corner0_i     (out_o.corner0),
  .corner1_i     (out_o.corner1),
  .corner2_i     (out_o.corner2),
  .corner3_i     (out_o.corner3),
  .piece_group_i (out_o.piece_group),
  .last_i        (out_o.last)
);
